// ===== src/lswn_pkg.sv =====
// shared types and constants of the line sensor window normalizer
`default_nettype none

package lswn_pkg;

   localparam int SAMPLE_W  = 12;
   localparam int KIND_W    = 3;
   localparam int FRAC_W    = 16;
   localparam int Q_W       = FRAC_W + 1;
   localparam int ERR_W     = Q_W + 1;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = Q_W;
   localparam int DIV_NUM_W = SAMPLE_W + FRAC_W;
   localparam int DIV_DEN_W = SAMPLE_W;

   localparam logic [Q_W-1:0]      Q_ONE          = Q_W'(65536);
   localparam logic [SAMPLE_W-1:0] RAW_MIN_RESET  = SAMPLE_W'(0);
   localparam logic [SAMPLE_W-1:0] RAW_MAX_RESET  = SAMPLE_W'(4095);
   localparam logic [Q_W-1:0]      CENTER_RESET   = Q_W'(32768);

   typedef enum logic [KIND_W-1:0] {
      KIND_SAMPLE = 3'd0,
      KIND_READ   = 3'd1,
      KIND_PEEK   = 3'd2,
      KIND_START  = 3'd3,
      KIND_STOP   = 3'd4
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RAW_MIN = 2'd0,
      CSR_RAW_MAX = 2'd1,
      CSR_CENTER  = 2'd2,
      CSR_INVERT  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_MEAN,
      ST_CAL,
      ST_NORM,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== src/lswn_chan_if.sv =====
// request and response channel interfaces
`default_nettype none

interface lswn_req_if;
   logic                              valid;
   logic                              ready;
   logic [lswn_pkg::KIND_W-1:0]       kind;
   logic [lswn_pkg::SAMPLE_W-1:0]     sample_value;

   modport source (output valid, output kind, output sample_value, input ready);
   modport sink   (input valid, input kind, input sample_value, output ready);
endinterface

interface lswn_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              is_active;
   logic                              was_fresh;
   logic [lswn_pkg::SAMPLE_W-1:0]     raw_average;
   logic [lswn_pkg::Q_W-1:0]          normalized;
   logic signed [lswn_pkg::ERR_W-1:0] position_error;

   modport source (output valid, output is_active, output was_fresh, output raw_average,
                   output normalized, output position_error, input ready);
   modport sink   (input valid, input is_active, input was_fresh, input raw_average,
                   input normalized, input position_error, output ready);
endinterface

`default_nettype wire

// ===== src/lswn_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module lswn_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/lswn_div.sv =====
// restoring serial divider, one quotient bit per cycle
`default_nettype none

module lswn_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [lswn_pkg::DIV_NUM_W-1:0] num,
   input  wire logic [lswn_pkg::DIV_DEN_W-1:0] den,
   output      logic                           busy,
   output      logic                           done,
   output      logic [lswn_pkg::DIV_NUM_W-1:0] quot
);

   localparam int NUM_W = lswn_pkg::DIV_NUM_W;
   localparam int DEN_W = lswn_pkg::DIV_DEN_W;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [NUM_W-1:0] q_ff;
   logic [DEN_W:0]   trial;
   logic             fits;
   logic [DEN_W:0]   diff;

   always_comb begin
      trial = {rem_ff, q_ff[NUM_W-1]};
      fits  = (trial >= {1'b0, den_ff});
      diff  = trial - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         q_ff   <= {q_ff[NUM_W-2:0], fits};
         rem_ff <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = q_ff;

endmodule

`default_nettype wire

// ===== src/line_sensor_window_normalizer_top.sv =====
// top level: window store, sequencer and calibration of the line sensor normalizer
//
// Keeps the last WINDOW_LEN samples in a small ram and answers read and peek items with the
// window mean calibrated to unsigned Q.16. Sample, start and stop items produce no response.
// An active read or peek holds the input until its response is loaded. The window is summed
// one ram read per cycle. The mean is formed by reciprocal multiplication in ST_MEAN and
// calibrated in ST_CAL. The 28-bit serial divider then forms the calibration ratio, one
// quotient bit per cycle, and ST_DONE loads the response. When the mean clamps or the
// calibration span is empty the divider is skipped. A read or peek while inactive skips the
// sum and goes straight to ST_DONE. A response that still waits for ready adds its stall
// cycles. The window reads as zero from reset until each slot is written; no clearing pass
// is needed. A finished response waits in the output register while the next item is taken.
`default_nettype none

module line_sensor_window_normalizer_top #(
   parameter int WINDOW_LEN = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   lswn_req_if.sink                                  req_if,
   lswn_rsp_if.source                                rsp_if,
   input  wire logic                                 csr_we,
   input  wire logic [lswn_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [lswn_pkg::CSR_W-1:0]           csr_wdata
);

   localparam int ADDR_W = $clog2(WINDOW_LEN);
   localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
   localparam int SW     = lswn_pkg::SAMPLE_W;
   localparam int SUM_W  = SW + $clog2(WINDOW_LEN);
   localparam int PROD_W = 2 * SUM_W + 1;
   localparam int NUM_W  = lswn_pkg::DIV_NUM_W;
   localparam int DEN_W  = lswn_pkg::DIV_DEN_W;
   localparam int FRAC_W = lswn_pkg::FRAC_W;
   localparam int Q_W    = lswn_pkg::Q_W;
   localparam int ERR_W  = lswn_pkg::ERR_W;

   localparam logic [ADDR_W-1:0] HALF_SLOT = ADDR_W'(WINDOW_LEN / 2 - 1);
   localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(WINDOW_LEN - 1);
   localparam logic [CNT_W-1:0]  CNT_END   = CNT_W'(WINDOW_LEN);
   // ceil(2^(SUM_W+ADDR_W) / WINDOW_LEN), exact floor division for any window sum
   localparam logic [SUM_W:0]    MEAN_RECIP = (SUM_W + 1)'(
      ((longint'(1) << (SUM_W + ADDR_W)) + longint'(WINDOW_LEN) - longint'(1))
      / longint'(WINDOW_LEN));

   lswn_pkg::state_type state_ff;
   lswn_pkg::state_type state_in;

   logic                  active_ff;
   logic                  fresh_ff;
   logic [ADDR_W-1:0]     slot_ff;
   logic [WINDOW_LEN-1:0] valid_ff;
   logic [SW-1:0]         min_ff;
   logic [SW-1:0]         max_ff;
   logic [Q_W-1:0]        center_ff;
   logic                  invert_ff;

   logic [CNT_W-1:0]      idx_ff;
   logic                  pend_ff;
   logic                  pend_ok_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [SW-1:0]         avg_ff;
   logic [Q_W-1:0]        norm_ff;
   logic                  act_cap_ff;
   logic                  fresh_cap_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_active_ff;
   logic                  rsp_fresh_ff;
   logic [SW-1:0]         rsp_avg_ff;
   logic [Q_W-1:0]        rsp_norm_ff;
   logic [ERR_W-1:0]      rsp_err_ff;

   logic                  accept;
   logic                  is_query;
   logic                  sum_last;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [SW-1:0]         rd_data;
   logic                  ram_we;
   logic [PROD_W-1:0]     mean_prod;
   logic                  div_start;
   logic                  div_busy;
   logic                  div_done;
   logic [NUM_W-1:0]      div_num;
   logic [DEN_W-1:0]      div_den;
   logic [NUM_W-1:0]      div_quot;
   logic                  out_load;
   logic                  cal_bad;
   logic                  cal_div;
   logic [Q_W-1:0]        cal_n;
   logic [Q_W-1:0]        cal_inv;
   logic [Q_W-1:0]        quot_inv;
   logic [ERR_W-1:0]      err_calc;

   assign accept   = req_if.valid & req_if.ready;
   assign is_query = (req_if.kind == lswn_pkg::KIND_READ) || (req_if.kind == lswn_pkg::KIND_PEEK);
   assign sum_last = (idx_ff == CNT_END) && !pend_ff;
   assign rd_addr  = idx_ff[ADDR_W-1:0];

   // window mean by reciprocal multiplication
   assign mean_prod = PROD_W'(sum_ff) * PROD_W'(MEAN_RECIP);

   // calibration decisions on the registered mean
   always_comb begin
      cal_bad  = (max_ff <= min_ff);
      cal_div  = !cal_bad && (avg_ff > min_ff) && (avg_ff < max_ff);
      cal_n    = (avg_ff >= max_ff) ? lswn_pkg::Q_ONE : '0;
      cal_inv  = invert_ff ? (lswn_pkg::Q_ONE - cal_n) : cal_n;
      quot_inv = invert_ff ? (lswn_pkg::Q_ONE - div_quot[Q_W-1:0]) : div_quot[Q_W-1:0];
      err_calc = {1'b0, norm_ff} - {1'b0, center_ff};
   end

   always_comb begin
      div_num = {avg_ff - min_ff, {FRAC_W{1'b0}}};
      div_den = max_ff - min_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lswn_pkg::ST_IDLE: begin
            if (accept && is_query) begin
               state_in = active_ff ? lswn_pkg::ST_SUM : lswn_pkg::ST_DONE;
            end
         end
         lswn_pkg::ST_SUM: begin
            if (sum_last) begin
               state_in = lswn_pkg::ST_MEAN;
            end
         end
         lswn_pkg::ST_MEAN: begin
            state_in = lswn_pkg::ST_CAL;
         end
         lswn_pkg::ST_CAL: begin
            state_in = cal_div ? lswn_pkg::ST_NORM : lswn_pkg::ST_DONE;
         end
         lswn_pkg::ST_NORM: begin
            if (div_done) begin
               state_in = lswn_pkg::ST_DONE;
            end
         end
         lswn_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               state_in = lswn_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lswn_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_if.ready = 1'b0;
      rd_en        = 1'b0;
      div_start    = 1'b0;
      out_load     = 1'b0;
      case (state_ff)
         lswn_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
         end
         lswn_pkg::ST_SUM: begin
            rd_en = (idx_ff < CNT_END);
         end
         lswn_pkg::ST_CAL: begin
            div_start = cal_div;
         end
         lswn_pkg::ST_DONE: begin
            out_load = !rsp_valid_ff || rsp_if.ready;
         end
         default: begin
            req_if.ready = 1'b0;
         end
      endcase
   end

   assign ram_we = accept && (req_if.kind == lswn_pkg::KIND_SAMPLE) && active_ff;

   lswn_ram #(
      .WIDTH (SW),
      .DEPTH (WINDOW_LEN)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot_ff),
      .wr_data (req_if.sample_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lswn_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lswn_pkg::ST_IDLE;
         active_ff    <= 1'b0;
         fresh_ff     <= 1'b0;
         slot_ff      <= '0;
         valid_ff     <= '0;
         min_ff       <= lswn_pkg::RAW_MIN_RESET;
         max_ff       <= lswn_pkg::RAW_MAX_RESET;
         center_ff    <= lswn_pkg::CENTER_RESET;
         invert_ff    <= 1'b0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            case (csr_index)
               lswn_pkg::CSR_RAW_MIN: min_ff <= csr_wdata[SW-1:0];
               lswn_pkg::CSR_RAW_MAX: max_ff <= csr_wdata[SW-1:0];
               lswn_pkg::CSR_CENTER: begin
                  center_ff <= (csr_wdata > lswn_pkg::Q_ONE) ? lswn_pkg::Q_ONE : csr_wdata;
               end
               lswn_pkg::CSR_INVERT:  invert_ff <= csr_wdata[0];
               default: begin
                  invert_ff <= invert_ff;
               end
            endcase
         end

         if (accept) begin
            case (req_if.kind)
               lswn_pkg::KIND_SAMPLE: begin
                  if (active_ff) begin
                     valid_ff[slot_ff] <= 1'b1;
                     slot_ff <= (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
                     if (slot_ff == HALF_SLOT || slot_ff == LAST_SLOT) begin
                        fresh_ff <= 1'b1;
                     end
                  end
               end
               lswn_pkg::KIND_READ: begin
                  if (active_ff) begin
                     fresh_ff <= 1'b0;
                  end
                  idx_ff  <= '0;
                  pend_ff <= 1'b0;
               end
               lswn_pkg::KIND_PEEK: begin
                  idx_ff  <= '0;
                  pend_ff <= 1'b0;
               end
               lswn_pkg::KIND_START: begin
                  active_ff <= 1'b1;
                  fresh_ff  <= 1'b0;
                  slot_ff   <= '0;
               end
               lswn_pkg::KIND_STOP: begin
                  active_ff <= 1'b0;
                  fresh_ff  <= 1'b0;
               end
               default: begin
                  active_ff <= active_ff;
               end
            endcase
         end

         if (state_ff == lswn_pkg::ST_SUM) begin
            pend_ff <= rd_en;
            if (rd_en) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept && is_query) begin
         act_cap_ff   <= active_ff;
         fresh_cap_ff <= fresh_ff & active_ff;
         sum_ff       <= '0;
         avg_ff       <= '0;
         norm_ff      <= center_ff;
      end
      if (state_ff == lswn_pkg::ST_SUM) begin
         pend_ok_ff <= valid_ff[rd_addr];
         if (pend_ff && pend_ok_ff) begin
            sum_ff <= sum_ff + SUM_W'(rd_data);
         end
      end
      if (state_ff == lswn_pkg::ST_MEAN) begin
         avg_ff <= mean_prod[SUM_W + ADDR_W +: SW];
      end
      if (state_ff == lswn_pkg::ST_CAL && !cal_div) begin
         norm_ff <= cal_bad ? '0 : cal_inv;
      end
      if (state_ff == lswn_pkg::ST_NORM && div_done) begin
         norm_ff <= quot_inv;
      end
      if (out_load) begin
         rsp_active_ff <= act_cap_ff;
         rsp_fresh_ff  <= fresh_cap_ff;
         rsp_avg_ff    <= avg_ff;
         rsp_norm_ff   <= norm_ff;
         rsp_err_ff    <= err_calc;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.is_active      = rsp_active_ff;
   assign rsp_if.was_fresh      = rsp_fresh_ff;
   assign rsp_if.raw_average    = rsp_avg_ff;
   assign rsp_if.normalized     = rsp_norm_ff;
   assign rsp_if.position_error = $signed(rsp_err_ff);

`ifndef SYNTHESIS
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   a_query_active_sums: assert property (@(posedge clock) disable iff (reset)
      (accept && is_query && active_ff) |=> (state_ff == lswn_pkg::ST_SUM))
      else $error("active query did not start window sum");

   a_sample_advances: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> (slot_ff != $past(slot_ff)))
      else $error("write slot did not advance on sample");

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.kind == lswn_pkg::KIND_STOP) |=> (!active_ff && !fresh_ff))
      else $error("stop left acquisition or fresh flag set");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_norm_ff <= lswn_pkg::Q_ONE))
      else $error("normalized value out of range");
`endif

endmodule

`default_nettype wire
